// ----- design/icre_pkg.sv -----
// Shared types, register indexes and fixed-point helpers for the ionic current rate evaluator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package icre_pkg;

    localparam int FRAC_BITS_DEF         = 16;
    localparam int RATE_DENOM_OFFSET_DEF = 19661;
    localparam int RECOVERY_SHIFT_DEF    = 9830;
    localparam int STIM_SCALE_DEF        = 65536;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLTAGE_OFFSET = 3'd0,
        REG_SCALE_INVERSE  = 3'd1,
        REG_CURRENT_GAIN   = 3'd2,
        REG_TIME_INVERSE   = 3'd3,
        REG_EXC_GAIN       = 3'd4,
        REG_THRESHOLD      = 3'd5,
        REG_BASE_RATE      = 3'd6,
        REG_FEEDBACK       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] voltage_offset;
        logic        [30:0] voltage_scale_inverse;
        logic        [30:0] current_gain;
        logic        [30:0] time_scale_inverse;
        logic        [30:0] excitation_gain;
        logic        [30:0] threshold_level;
        logic        [30:0] recovery_base_rate;
        logic        [30:0] recovery_feedback;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] membrane_voltage;
        logic signed [31:0] recovery_value;
        logic signed [31:0] stimulus_current;
    } t_in;

    typedef struct packed {
        logic signed [31:0] ionic_current;
        logic signed [31:0] recovery_rate;
        logic               saturated_flag;
    } t_out;

    // Front-end results handed to the divider
    typedef struct packed {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic signed [31:0] h;
        logic signed [31:0] iong;
        logic signed [31:0] squo;
        logic               flag;
    } t_fwd;

    typedef struct packed {
        logic signed [31:0] v;
        logic               c;
    } t_sat;

    function automatic t_sat sat32(input logic signed [65:0] x);
        t_sat r;
        if (x > $signed(66'h0_7FFF_FFFF)) begin
            r.v = 32'sh7FFF_FFFF;
            r.c = 1'b1;
        end else if (x < -66'sd2147483648) begin
            r.v = 32'sh8000_0000;
            r.c = 1'b1;
        end else begin
            r.v = x[31:0];
            r.c = 1'b0;
        end
        return r;
    endfunction

    // Product shifted right with floor rounding, then clipped
    function automatic t_sat fmul(input logic signed [31:0] a, input logic signed [31:0] b,
                                  input int frac);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat32(66'(p >>> frac));
    endfunction

    function automatic logic signed [31:0] uext(input logic [30:0] u);
        return $signed({1'b0, u});
    endfunction

endpackage
`default_nettype wire

// ----- design/icre_front.sv -----
// Front pipeline: normalization, cubic ionic current, recovery terms and the stimulus
// quotient, six stages. Depends on icre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icre_front #(
    parameter int FRAC_BITS         = icre_pkg::FRAC_BITS_DEF,
    parameter int RATE_DENOM_OFFSET = icre_pkg::RATE_DENOM_OFFSET_DEF,
    parameter int RECOVERY_SHIFT    = icre_pkg::RECOVERY_SHIFT_DEF,
    parameter int STIM_SCALE        = icre_pkg::STIM_SCALE_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ce,
    input  wire logic          i_valid,
    input  wire icre_pkg::t_in i_data,
    input  wire icre_pkg::t_cfg i_cfg,
    output logic               o_valid,
    output icre_pkg::t_fwd     o_fwd
);
    import icre_pkg::*;

    localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] M2  = 66'(RATE_DENOM_OFFSET);
    localparam logic signed [65:0] BSH = 66'(RECOVERY_SHIFT);

    // Reciprocal of the stimulus scale: ceil(2^(FRAC_BITS+64) / STIM_SCALE), split in words
    localparam logic [191:0] SC_M = ((192'd1 << (FRAC_BITS + 64)) + 192'(STIM_SCALE)
                                     - 192'd1) / 192'(STIM_SCALE);
    localparam logic [31:0]  SC_M0 = SC_M[31:0];
    localparam logic [31:0]  SC_M1 = SC_M[63:32];
    localparam logic [31:0]  SC_M2 = SC_M[95:64];

    logic               r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic signed [31:0] r1_vsum, r1_fb, r1_r;
    logic [63:0]        r1_sp0, r1_sp1, r1_sp2;
    logic               r1_sneg;
    logic               r1_f;
    logic signed [31:0] r2_vn, r2_fb, r2_r;
    logic [32:0]        r2_sc;
    logic [63:0]        r2_sp2;
    logic               r2_sneg;
    logic               r2_f;
    logic signed [31:0] r3_a1, r3_d1, r3_c1, r3_rv, r3_den, r3_p, r3_fb, r3_r;
    logic [63:0]        r3_sq;
    logic               r3_sneg;
    logic               r3_f;
    logic signed [31:0] r4_a2, r4_m, r4_c1, r4_rv, r4_den, r4_fb, r4_r, r4_squo;
    logic               r4_f;
    logic signed [31:0] r5_a3, r5_h, r5_rv, r5_den, r5_fb, r5_squo;
    logic               r5_f;
    logic signed [31:0] r6_iong, r6_h, r6_den, r6_fb, r6_squo;
    logic               r6_f;

    t_sat s1_vsum, s1_fb, s2_vn;
    t_sat s3_a1, s3_d1, s3_c1, s3_rv, s3_den, s3_s, s3_p;
    t_sat s4_a2, s4_m, s5_a3, s5_h, s6_ion, s6_iong;
    t_sat s4_squo;
    logic [31:0] s1_smag;
    logic [96:0] s2_smid;

    always_comb begin
        s1_vsum = sat32(66'(i_data.membrane_voltage) + 66'(i_cfg.voltage_offset));
        s1_fb   = fmul(uext(i_cfg.recovery_feedback), i_data.recovery_value, FRAC_BITS);
        s2_vn   = fmul(r1_vsum, uext(i_cfg.voltage_scale_inverse), FRAC_BITS);
        s3_a1   = fmul(uext(i_cfg.excitation_gain), r2_vn, FRAC_BITS);
        s3_d1   = sat32(66'(r2_vn) - 66'(uext(i_cfg.threshold_level)));
        s3_c1   = sat32(ONE - 66'(r2_vn));
        s3_rv   = fmul(r2_r, r2_vn, FRAC_BITS);
        s3_den  = sat32(M2 + 66'(r2_vn));
        s3_s    = sat32(66'(r2_vn) - BSH - ONE);
        s3_p    = fmul(r2_vn, s3_s.v, FRAC_BITS);
        s4_a2   = fmul(r3_a1, r3_d1, FRAC_BITS);
        s4_m    = fmul(uext(i_cfg.excitation_gain), r3_p, FRAC_BITS);
        s5_a3   = fmul(r4_a2, r4_c1, FRAC_BITS);
        s5_h    = sat32(-66'(r4_r) - 66'(r4_m));
        s6_ion  = sat32(66'(r5_rv) - 66'(r5_a3));
        s6_iong = fmul(s6_ion.v, uext(i_cfg.current_gain), FRAC_BITS);

        // Stimulus quotient: magnitude times reciprocal, keep bits 64 and up
        s1_smag = i_data.stimulus_current[31] ? 32'(-i_data.stimulus_current)
                                              : i_data.stimulus_current;
        s2_smid = 97'(r1_sp0) + {1'b0, r1_sp1, 32'd0};
        if (r3_sneg) begin
            if (r3_sq > 64'h0000_0000_8000_0000) begin
                s4_squo.v = 32'sh8000_0000;
                s4_squo.c = 1'b1;
            end else begin
                s4_squo.v = 32'(-r3_sq);
                s4_squo.c = 1'b0;
            end
        end else begin
            if (r3_sq > 64'h0000_0000_7FFF_FFFF) begin
                s4_squo.v = 32'sh7FFF_FFFF;
                s4_squo.c = 1'b1;
            end else begin
                s4_squo.v = r3_sq[31:0];
                s4_squo.c = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            r4_v <= 1'b0; r5_v <= 1'b0; r6_v <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid; r2_v <= r1_v; r3_v <= r2_v;
            r4_v <= r3_v;    r5_v <= r4_v; r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_vsum <= s1_vsum.v;
            r1_fb   <= s1_fb.v;
            r1_r    <= i_data.recovery_value;
            r1_sp0  <= 64'(s1_smag) * 64'(SC_M0);
            r1_sp1  <= 64'(s1_smag) * 64'(SC_M1);
            r1_sp2  <= 64'(s1_smag) * 64'(SC_M2);
            r1_sneg <= i_data.stimulus_current[31];
            r1_f    <= s1_vsum.c | s1_fb.c;

            r2_vn   <= s2_vn.v;
            r2_fb   <= r1_fb;
            r2_r    <= r1_r;
            r2_sc   <= s2_smid[96:64];
            r2_sp2  <= r1_sp2;
            r2_sneg <= r1_sneg;
            r2_f    <= r1_f | s2_vn.c;

            r3_a1   <= s3_a1.v;
            r3_d1   <= s3_d1.v;
            r3_c1   <= s3_c1.v;
            r3_rv   <= s3_rv.v;
            r3_den  <= s3_den.v;
            r3_p    <= s3_p.v;
            r3_fb   <= r2_fb;
            r3_r    <= r2_r;
            r3_sq   <= r2_sp2 + 64'(r2_sc);
            r3_sneg <= r2_sneg;
            r3_f    <= r2_f | s3_a1.c | s3_d1.c | s3_c1.c | s3_rv.c | s3_den.c
                       | s3_s.c | s3_p.c;

            r4_a2   <= s4_a2.v;
            r4_m    <= s4_m.v;
            r4_c1   <= r3_c1;
            r4_rv   <= r3_rv;
            r4_den  <= r3_den;
            r4_fb   <= r3_fb;
            r4_r    <= r3_r;
            r4_squo <= s4_squo.v;
            r4_f    <= r3_f | s4_a2.c | s4_m.c | s4_squo.c;

            r5_a3   <= s5_a3.v;
            r5_h    <= s5_h.v;
            r5_rv   <= r4_rv;
            r5_den  <= r4_den;
            r5_fb   <= r4_fb;
            r5_squo <= r4_squo;
            r5_f    <= r4_f | s5_a3.c | s5_h.c;

            r6_iong <= s6_iong.v;
            r6_h    <= r5_h;
            r6_den  <= r5_den;
            r6_fb   <= r5_fb;
            r6_squo <= r5_squo;
            r6_f    <= r5_f | s6_ion.c | s6_iong.c;
        end
    end

    assign o_valid    = r6_v;
    assign o_fwd.num  = r6_fb;
    assign o_fwd.den  = r6_den;
    assign o_fwd.h    = r6_h;
    assign o_fwd.iong = r6_iong;
    assign o_fwd.squo = r6_squo;
    assign o_fwd.flag = r6_f;
endmodule
`default_nettype wire

// ----- design/icre_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with saturation and sideband.
// Depends on icre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icre_div #(
    parameter int FRAC_BITS = icre_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_ce,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    input  wire logic [SIDE_W-1:0]  i_side,
    output logic                    o_valid,
    output logic signed [31:0]      o_quo,
    output logic                    o_clip,
    output logic [SIDE_W-1:0]       o_side
);
    import icre_pkg::*;

    localparam int QW = 32 + FRAC_BITS;

    logic              r_v    [0:QW];
    logic [31:0]       r_rem  [0:QW];
    logic [QW-1:0]     r_q    [0:QW];
    logic [31:0]       r_d    [0:QW];
    logic              r_neg  [0:QW];
    logic              r_zero [0:QW];
    logic              r_nneg [0:QW];
    logic [SIDE_W-1:0] r_side [0:QW];

    logic               r_ov;
    logic signed [31:0] r_quo;
    logic               r_clip;
    logic [SIDE_W-1:0]  r_oside;

    logic [31:0] w_nmag, w_dmag;
    assign w_nmag = i_num[31] ? 32'(-i_num) : i_num;
    assign w_dmag = i_den[31] ? 32'(-i_den) : i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem[0]  <= '0;
            r_q[0]    <= {w_nmag, {FRAC_BITS{1'b0}}};
            r_d[0]    <= w_dmag;
            r_neg[0]  <= i_num[31] ^ i_den[31];
            r_zero[0] <= (i_den == 32'sd0);
            r_nneg[0] <= i_num[31];
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [32:0] w_sh;
        logic        w_ge;
        assign w_sh = {r_rem[k-1], r_q[k-1][QW-1]};
        assign w_ge = (w_sh >= {1'b0, r_d[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= w_ge ? 32'(w_sh - {1'b0, r_d[k-1]}) : w_sh[31:0];
                r_q[k]    <= {r_q[k-1][QW-2:0], w_ge};
                r_d[k]    <= r_d[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
                r_nneg[k] <= r_nneg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Apply sign and clip to the signed 32-bit range; a zero divisor saturates by the numerator's sign
    logic signed [31:0] n_quo;
    logic               n_clip;
    always_comb begin
        if (r_zero[QW]) begin
            n_quo  = r_nneg[QW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n_clip = 1'b1;
        end else if (r_neg[QW]) begin
            if (r_q[QW] > QW'(33'h0_8000_0000)) begin
                n_quo  = 32'sh8000_0000;
                n_clip = 1'b1;
            end else begin
                n_quo  = 32'(-r_q[QW]);
                n_clip = 1'b0;
            end
        end else begin
            if (r_q[QW] > QW'(33'h0_7FFF_FFFF)) begin
                n_quo  = 32'sh7FFF_FFFF;
                n_clip = 1'b1;
            end else begin
                n_quo  = r_q[QW][31:0];
                n_clip = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ce) begin
            r_ov <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_quo   <= n_quo;
            r_clip  <= n_clip;
            r_oside <= r_side[QW];
        end
    end

    assign o_valid = r_ov;
    assign o_quo   = r_quo;
    assign o_clip  = r_clip;
    assign o_side  = r_oside;
endmodule
`default_nettype wire

// ----- design/icre_back.sv -----
// Back pipeline: recovery rate assembly, stimulus add and time rescale, two stages.
// Depends on icre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icre_back #(
    parameter int FRAC_BITS = icre_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_ce,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_quo,
    input  wire logic               i_quo_clip,
    input  wire logic signed [31:0] i_squo,
    input  wire logic signed [31:0] i_h,
    input  wire logic signed [31:0] i_iong,
    input  wire logic               i_flag,
    input  wire icre_pkg::t_cfg     i_cfg,
    output logic                    o_valid,
    output icre_pkg::t_out          o_data
);
    import icre_pkg::*;

    logic               r1_v, r2_v;
    logic signed [31:0] r1_fr, r1_ion;
    logic               r1_f;
    t_out               r2_data;

    t_sat s1_g, s1_fr, s1_ion, s2_fo;

    always_comb begin
        s1_g   = sat32(66'(uext(i_cfg.recovery_base_rate)) + 66'(i_quo));
        s1_fr  = fmul(s1_g.v, i_h, FRAC_BITS);
        s1_ion = sat32(66'(i_iong) + 66'(i_squo));
        s2_fo  = fmul(r1_fr, uext(i_cfg.time_scale_inverse), FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_fr  <= s1_fr.v;
            r1_ion <= s1_ion.v;
            r1_f   <= i_flag | i_quo_clip | s1_g.c | s1_fr.c | s1_ion.c;
            r2_data.ionic_current  <= r1_ion;
            r2_data.recovery_rate  <= s2_fo.v;
            r2_data.saturated_flag <= r1_f | s2_fo.c;
        end
    end

    assign o_valid = r2_v;
    assign o_data  = r2_data;
endmodule
`default_nettype wire

// ----- design/ionic_current_rate_eval.sv -----
// Depth from input transaction to result (Q16.16 by default): six front stages,
//   FRAC_BITS + 34 divider stages, two back stages.
// Throughput: one transaction per cycle unless stalled; the bit-serial divider pipeline
//   sets the depth, one quotient bit per stage, so the rate holds whatever the divisor.
// Reset (synchronous, active low): empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module ionic_current_rate_eval #(
    parameter int FRAC_BITS         = icre_pkg::FRAC_BITS_DEF,
    parameter int RATE_DENOM_OFFSET = icre_pkg::RATE_DENOM_OFFSET_DEF,
    parameter int RECOVERY_SHIFT    = icre_pkg::RECOVERY_SHIFT_DEF,
    parameter int STIM_SCALE        = icre_pkg::STIM_SCALE_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire icre_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output icre_pkg::t_out                         o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [icre_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [icre_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import icre_pkg::*;

    // Configuration registers: to be written only while idle, by the user; the block has no guard, so no shadowing
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.voltage_offset        <= 32'sd5242880;
            r_cfg.voltage_scale_inverse <= 31'd655;
            r_cfg.current_gain          <= 31'd508031;
            r_cfg.time_scale_inverse    <= 31'd5080;
            r_cfg.excitation_gain       <= 31'd524288;
            r_cfg.threshold_level       <= 31'd655;
            r_cfg.recovery_base_rate    <= 31'd131;
            r_cfg.recovery_feedback     <= 31'd13107;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_VOLTAGE_OFFSET: r_cfg.voltage_offset        <= i_cfg_data;
                REG_SCALE_INVERSE:  r_cfg.voltage_scale_inverse <= i_cfg_data[30:0];
                REG_CURRENT_GAIN:   r_cfg.current_gain          <= i_cfg_data[30:0];
                REG_TIME_INVERSE:   r_cfg.time_scale_inverse    <= i_cfg_data[30:0];
                REG_EXC_GAIN:       r_cfg.excitation_gain       <= i_cfg_data[30:0];
                REG_THRESHOLD:      r_cfg.threshold_level       <= i_cfg_data[30:0];
                REG_BASE_RATE:      r_cfg.recovery_base_rate    <= i_cfg_data[30:0];
                REG_FEEDBACK:       r_cfg.recovery_feedback     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // One pipeline-wide enable: advance whenever the output register is empty
    // or its result is being taken. Every stage holds together on a stall.
    logic w_ce;
    assign w_ce       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_ce;

    logic  w_fv;
    t_fwd  w_fwd;

    // The front also forms the stimulus quotient by reciprocal multiplication
    icre_front #(
        .FRAC_BITS         (FRAC_BITS),
        .RATE_DENOM_OFFSET (RATE_DENOM_OFFSET),
        .RECOVERY_SHIFT    (RECOVERY_SHIFT),
        .STIM_SCALE        (STIM_SCALE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .o_valid (w_fv),
        .o_fwd   (w_fwd)
    );

    // Recovery quotient lane carries h, the rescaled ionic current, the
    // stimulus quotient and the front flag alongside
    logic               w_dv;
    logic signed [31:0] w_quo;
    logic               w_quo_clip;
    logic [96:0]        w_side;

    icre_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (97)
    ) u_div_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_fv),
        .i_num   (w_fwd.num),
        .i_den   (w_fwd.den),
        .i_side  ({w_fwd.h, w_fwd.iong, w_fwd.squo, w_fwd.flag}),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_clip  (w_quo_clip),
        .o_side  (w_side)
    );

    icre_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ce        (w_ce),
        .i_valid     (w_dv),
        .i_quo       (w_quo),
        .i_quo_clip  (w_quo_clip),
        .i_squo      ($signed(w_side[32:1])),
        .i_h         ($signed(w_side[96:65])),
        .i_iong      ($signed(w_side[64:33])),
        .i_flag      (w_side[0]),
        .i_cfg       (r_cfg),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data)
    );
endmodule
`default_nettype wire

// ----- design/icre_chk.sv -----
// Port-level checker for the ionic current rate evaluator, bound to the top level.
// Depends on icre_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icre_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_in_ready,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire icre_pkg::t_out                  o_out_data
);
    import icre_pkg::*;

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not track output stall");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");
endmodule

bind ionic_current_rate_eval icre_chk u_icre_chk (.*);
`default_nettype wire

// ----- test/tb_ionic_current_rate_eval.sv -----
// Self-checking testbench for ionic_current_rate_eval: directed table, then random traffic
// under several register settings and flow-control phases. Depends on design/icre_pkg.sv and the design files.
`timescale 1ns / 1ps
module tb_ionic_current_rate_eval;
    import icre_pkg::*;

    localparam int     FRAC      = FRAC_BITS_DEF;
    localparam longint ONE_Q     = longint'(1) <<< FRAC;
    localparam longint S32_HI    = 64'sd2147483647;
    localparam longint S32_LO    = -64'sd2147483648;
    localparam int     LATENCY   = 42 + FRAC;
    localparam int     CYCLE_CAP = 400000;
    localparam int     RAND_PER_SET = 235;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ionic_current_rate_eval i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Clock: 12 ns period, first rising edge after the inputs are set
    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // Mirror of the register file, held at full precision
    longint cell_offset, cell_scale_inv, cell_gain, cell_time_inv;
    longint cell_exc, cell_thresh, cell_base, cell_feedback;
    bit     clip_hit;

    t_out   pending_results[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_req = 1'b0;
    int     cycle_count = 0;

    // ---------------- rate predictor ----------------
    function automatic longint clamp32(longint x);
        if (x > S32_HI) begin
            clip_hit = 1'b1;
            return S32_HI;
        end
        if (x < S32_LO) begin
            clip_hit = 1'b1;
            return S32_LO;
        end
        return x;
    endfunction

    // Arithmetic shift of a signed product is the floor rounding
    function automatic longint qmul(longint a, longint b);
        return clamp32((a * b) >>> FRAC);
    endfunction

    function automatic longint qdiv(longint num, longint den);
        if (den == 0) begin
            clip_hit = 1'b1;
            return (num < 0) ? S32_LO : S32_HI;
        end
        return clamp32((num * ONE_Q) / den);
    endfunction

    function automatic t_out rate_of(t_in d);
        longint volt, r, stim, vsum, vn, a, rv, ion, den, quo, g, s, m, h, fr;
        t_out   res;
        volt = longint'(d.membrane_voltage);
        r    = longint'(d.recovery_value);
        stim = longint'(d.stimulus_current);
        clip_hit = 1'b0;

        vsum = clamp32(volt + cell_offset);
        vn   = qmul(vsum, cell_scale_inv);

        // cubic excitation term and ionic current
        a   = qmul(cell_exc, vn);
        a   = qmul(a, clamp32(vn - cell_thresh));
        a   = qmul(a, clamp32(ONE_Q - vn));
        rv  = qmul(r, vn);
        ion = clamp32(rv - a);

        // recovery rate with the feedback quotient
        den = clamp32(longint'(RATE_DENOM_OFFSET_DEF) + vn);
        quo = qdiv(qmul(cell_feedback, r), den);
        g   = clamp32(cell_base + quo);
        s   = clamp32(vn - longint'(RECOVERY_SHIFT_DEF) - ONE_Q);
        m   = qmul(cell_exc, qmul(vn, s));
        h   = clamp32(-r - m);
        fr  = qmul(g, h);

        res.ionic_current  = 32'(clamp32(qmul(ion, cell_gain)
                                 + qdiv(stim, longint'(STIM_SCALE_DEF))));
        res.recovery_rate  = 32'(qmul(fr, cell_time_inv));
        res.saturated_flag = clip_hit;
        return res;
    endfunction

    // ---------------- register port ----------------
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        case (idx)
            REG_VOLTAGE_OFFSET: cell_offset    = longint'($signed(val));
            REG_SCALE_INVERSE:  cell_scale_inv = longint'(val[30:0]);
            REG_CURRENT_GAIN:   cell_gain      = longint'(val[30:0]);
            REG_TIME_INVERSE:   cell_time_inv  = longint'(val[30:0]);
            REG_EXC_GAIN:       cell_exc       = longint'(val[30:0]);
            REG_THRESHOLD:      cell_thresh    = longint'(val[30:0]);
            REG_BASE_RATE:      cell_base      = longint'(val[30:0]);
            REG_FEEDBACK:       cell_feedback  = longint'(val[30:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold the sender until the pipeline is empty, then let it settle
    task automatic drain_pipeline();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // Load one full register setting: 0 default, 1 minimum offset and all else at maximum,
    // 2 zeros, 3 raw random words, 4 perturbed defaults, 5 unit scale with zero offset
    task automatic load_setting(int which);
        logic [31:0] vals [8];
        vals = '{32'd5242880, 32'd655, 32'd508031, 32'd5080,
                 32'd524288, 32'd655, 32'd131, 32'd13107};
        case (which)
            1: begin
                vals[0] = 32'h8000_0000;
                for (int k = 1; k < 8; k++) vals[k] = 32'hFFFF_FFFF;
            end
            2: for (int k = 0; k < 8; k++) vals[k] = 32'h0;
            3: for (int k = 0; k < 8; k++) vals[k] = $urandom;
            4: for (int k = 0; k < 8; k++)
                vals[k] = vals[k] + $urandom_range(0, vals[k] / 2 + 1);
            5: begin
                vals[0] = 32'h0;
                vals[1] = 32'd65536;
            end
            default: ;
        endcase
        drain_pipeline();
        for (int k = 0; k < 8; k++) write_reg(t_reg_idx'(k), vals[k]);
    endtask

    // ---------------- sender ----------------
    // Offer one transaction; valid holds until it is taken
    task automatic offer_item(t_in d, bit typed, t_out want);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = d;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_in_ready;
            if (taken) pending_results.push_back(typed ? want : rate_of(d));
            @(negedge i_clk);
        end
        i_in_valid = 1'b0;
    endtask

    function automatic t_in random_item(bit unit_cfg);
        t_in d;
        int  pick;
        pick = $urandom_range(99);
        if (pick < 75) begin
            // physiological node: -90..+40 mV, recovery 0..3, small stimulus
            d.membrane_voltage = $signed($urandom_range(0, 130 << 16)) - (90 << 16);
            d.recovery_value   = $signed($urandom_range(0, 3 << 16));
            d.stimulus_current = $signed($urandom_range(0, 100 << 16)) - (50 << 16);
        end else if (pick < 82 && unit_cfg) begin
            // near the pole of the recovery quotient
            d.membrane_voltage = -RATE_DENOM_OFFSET_DEF + $signed($urandom_range(0, 6)) - 3;
            d.recovery_value   = $urandom;
            d.stimulus_current = $urandom;
        end else begin
            d.membrane_voltage = $urandom;
            d.recovery_value   = $urandom;
            d.stimulus_current = $urandom;
        end
        return d;
    endfunction

    // ---------------- receiver ----------------
    always @(negedge i_clk) begin
        if (i_rst_n && hold_req) begin
            i_out_ready = 1'b0;
            repeat (300) @(negedge i_clk);
            hold_req = 1'b0;
        end
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", o_out_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.ionic_current !== want.ionic_current) begin
                    $error("ionic_current: expected %0d, got %0d",
                           want.ionic_current, o_out_data.ionic_current);
                    fail_count++;
                end
                if (o_out_data.recovery_rate !== want.recovery_rate) begin
                    $error("recovery_rate: expected %0d, got %0d",
                           want.recovery_rate, o_out_data.recovery_rate);
                    fail_count++;
                end
                if (o_out_data.saturated_flag !== want.saturated_flag) begin
                    $error("saturated_flag: expected %0d, got %0d",
                           want.saturated_flag, o_out_data.saturated_flag);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("** ionic_current_rate_eval: FAILED **");
            $finish;
        end
    end

    // ---------------- directed table ----------------
    typedef struct {
        t_in  d;
        bit   unit_cfg;
        bit   typed;
        t_out want;
    } t_dir_row;

    t_dir_row dir_rows[$];

    function automatic void add_row(int v, int r, int st, bit unit_cfg,
                                    bit typed = 1'b0, int ion = 0, int rate = 0,
                                    bit flag = 1'b0);
        t_dir_row row;
        row.d.membrane_voltage    = v;
        row.d.recovery_value      = r;
        row.d.stimulus_current    = st;
        row.unit_cfg              = unit_cfg;
        row.typed                 = typed;
        row.want.ionic_current    = ion;
        row.want.recovery_rate    = rate;
        row.want.saturated_flag   = flag;
        dir_rows.push_back(row);
    endfunction

    localparam int MV80  = 80 << 16;
    localparam int IMAX  = 32'h7FFF_FFFF;
    localparam int IMIN  = 32'h8000_0000;

    initial begin
        t_in  d;
        t_out none;
        bit   unit_applied;
        int   pha_send [4];
        int   pha_recv [4];

        pha_send    = '{0, 46, 0, 9};
        pha_recv    = '{0, 0, 46, 9};
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        none        = '0;
        cell_offset = 5242880; cell_scale_inv = 655; cell_gain = 508031;
        cell_time_inv = 5080;  cell_exc = 524288;   cell_thresh = 655;
        cell_base = 131;       cell_feedback = 13107;

        // At -80 mV the normalized voltage is zero: current is the stimulus, rate is zero
        add_row(-MV80, 0, 0,    1'b0, 1'b1, 0, 0, 1'b0);
        add_row(-MV80, 0, IMAX, 1'b0, 1'b1, IMAX, 0, 1'b0);
        add_row(-MV80, 0, IMIN, 1'b0, 1'b1, IMIN, 0, 1'b0);
        add_row(-MV80, 0, -1,   1'b0, 1'b1, -1, 0, 1'b0);
        // field extremes under the default setting
        add_row(IMAX, IMAX, IMAX, 1'b0);
        add_row(IMIN, IMIN, IMIN, 1'b0);
        add_row(IMAX, IMIN, 0,    1'b0);
        add_row(IMIN, IMAX, -1,   1'b0);
        add_row(0, 0, 0,          1'b0);
        add_row(-1, -1, -1,       1'b0);
        add_row(20 << 16, 1 << 16, 5 << 16, 1'b0);
        add_row(-85 << 16, 2 << 16, -3 << 16, 1'b0);
        // unit scale, zero offset: voltage maps straight to vn, so the pole is reachable
        add_row(-RATE_DENOM_OFFSET_DEF, 1 << 16, 0, 1'b1);
        add_row(-RATE_DENOM_OFFSET_DEF, -(1 << 16), 0, 1'b1);
        add_row(-RATE_DENOM_OFFSET_DEF, 0, 7, 1'b1);
        add_row(-RATE_DENOM_OFFSET_DEF + 1, IMAX, 0, 1'b1);
        add_row(-RATE_DENOM_OFFSET_DEF - 1, IMIN, 0, 1'b1);
        add_row(1 << 16, 0, 0, 1'b1);
        add_row(IMAX, 0, IMAX, 1'b1);
        add_row(IMIN, 0, IMIN, 1'b1);
        add_row(655, 1 << 16, 0, 1'b1);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk the directed table with no idling
        unit_applied = 1'b0;
        foreach (dir_rows[n]) begin
            if (dir_rows[n].unit_cfg && !unit_applied) begin
                drain_pipeline();
                write_reg(REG_VOLTAGE_OFFSET, 32'h0);
                write_reg(REG_SCALE_INVERSE, 32'd65536);
                @(negedge i_clk);
                unit_applied = 1'b1;
            end
            offer_item(dir_rows[n].d, dir_rows[n].typed, dir_rows[n].want);
        end

        // Random traffic: each register setting runs through the idling phases
        for (int set = 0; set < 6; set++) begin
            load_setting(set);
            @(negedge i_clk);
            for (int n = 0; n < RAND_PER_SET; n++) begin
                if (n % 60 == 0) begin
                    send_idle_pct  = pha_send[(n / 60 + set) % 4];
                    recv_stall_pct = pha_recv[(n / 60 + set) % 4];
                end
                d = random_item(set == 5);
                offer_item(d, 1'b0, none);
            end
            // Back-pressure: long receiver hold-off while the sender keeps pushing
            if (set == 1 || set == 4) begin
                send_idle_pct = 0;
                hold_req = 1'b1;
                for (int n = 0; n < 120; n++) begin
                    d = random_item(1'b0);
                    offer_item(d, 1'b0, none);
                end
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** ionic_current_rate_eval: PASSED **");
        end else begin
            $display("** ionic_current_rate_eval: FAILED **");
        end
        $finish;
    end

endmodule
